FILE: rtl/mcsc_pkg.sv
`timescale 1ns / 1ps

package mcsc_pkg;

  typedef logic [63:0] key_t;
  typedef logic [21:0] frame_t;
  typedef logic [7:0]  byte_t;
  typedef logic [0:0]  cfg_idx_t;

  localparam int LEN_ONE   = 19;
  localparam int LEN_TWO   = 22;
  localparam int LEN_THREE = 23;

  localparam key_t   KEY_RESET   = 64'h1234_5678_90AB_CDEF;
  localparam frame_t FRAME_RESET = 22'h134;

  localparam int WARMUP_STEPS = 100;
  localparam int WARM_CW      = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;

  localparam cfg_idx_t CFG_KEY   = 1'b0;
  localparam cfg_idx_t CFG_FRAME = 1'b1;

  // Key bit i lands at len-1-(i mod len), later bits win; then frame bits
  // are XORed in along the same wrapping walk.
  function automatic logic [22:0] load_bits(input key_t key, input frame_t frame,
                                            input int len);
    logic [22:0] res;
    int          pos;
    res = '0;
    pos = len - 1;
    for (int i = 0; i < 64; i++) begin
      res[pos] = key[i];
      pos = (pos == 0) ? len - 1 : pos - 1;
    end
    pos = len - 1;
    for (int i = 0; i < 22; i++) begin
      res[pos] = res[pos] ^ frame[i];
      pos = (pos == 0) ? len - 1 : pos - 1;
    end
    return res;
  endfunction

endpackage

FILE: rtl/mcsc_in_if.sv
`timescale 1ns / 1ps

interface mcsc_in_if;
  logic              valid;
  logic              ready;
  mcsc_pkg::byte_t   data_in;
  logic              start_of_message;

  modport source (output valid, data_in, start_of_message, input ready);
  modport sink   (input valid, data_in, start_of_message, output ready);
endinterface

FILE: rtl/mcsc_out_if.sv
`timescale 1ns / 1ps

interface mcsc_out_if;
  logic            valid;
  logic            ready;
  mcsc_pkg::byte_t data_out;

  modport source (output valid, data_out, input ready);
  modport sink   (input valid, data_out, output ready);
endinterface

FILE: rtl/mcsc_cfg_if.sv
`timescale 1ns / 1ps

interface mcsc_cfg_if;
  logic               valid;
  logic               ready;
  mcsc_pkg::cfg_idx_t index;
  mcsc_pkg::key_t     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/majority_clocked_lfsr_stream_cipher.sv
`timescale 1ns / 1ps

// Byte stream cipher with an A5/1-style keystream (three majority-clocked
// LFSRs of 19, 22 and 23 bits). Encrypt and decrypt are the same operation.
// Channels: in_ch carries data_in and start_of_message, out_ch carries
// data_out, cfg_ch writes cipher_key (index 0) or frame_number (index 1).
// cfg_ch is always ready; new values take effect at the next start beat.
// One shared step unit advances the registers once per cycle while warming
// up or running the keystream (it pauses in idle and hold):
//   plain beat: the keystream steps for the byte, then the output write.
//   start beat: key and frame load at the accept edge, then WARMUP_STEPS
//               warm-up steps, then the keystream steps as for a plain beat.
// in_ch.ready is high only while the sequencer is idle. The result sits in
// an output register, so the next beat is taken while it waits. If the
// receiver stalls and the register is still full when the next byte is
// done, the sequencer holds that byte until the register drains.
// Reset: key and frame return to their defaults, the LFSRs clear to zero
// (keystream of zero until the first start beat), the output empties.
module majority_clocked_lfsr_stream_cipher (
  input  logic               clk,
  input  logic               rst_n,
  mcsc_in_if.sink            in_ch,
  mcsc_out_if.source         out_ch,
  mcsc_cfg_if.sink           cfg_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WARM = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [mcsc_pkg::WARM_CW-1:0]  warm_cnt_r, warm_cnt_nxt;
  logic [2:0]                    bit_cnt_r, bit_cnt_nxt;
  logic [18:0]                   lfsr_one_r, lfsr_one_nxt;
  logic [21:0]                   lfsr_two_r, lfsr_two_nxt;
  logic [22:0]                   lfsr_three_r, lfsr_three_nxt;
  mcsc_pkg::key_t                key_r;
  mcsc_pkg::frame_t              frame_r;
  mcsc_pkg::byte_t               data_r, data_nxt;
  mcsc_pkg::byte_t               ks_r, ks_nxt;
  mcsc_pkg::byte_t               out_data_r, out_data_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [22:0]                   load_one, load_two, load_three;
  logic [18:0]                   step_one;
  logic [21:0]                   step_two;
  logic [22:0]                   step_three;
  logic                          maj, step_bit, in_fire, slot_free;

  assign load_one   = mcsc_pkg::load_bits(key_r, frame_r, mcsc_pkg::LEN_ONE);
  assign load_two   = mcsc_pkg::load_bits(key_r, frame_r, mcsc_pkg::LEN_TWO);
  assign load_three = mcsc_pkg::load_bits(key_r, frame_r, mcsc_pkg::LEN_THREE);

  // Shared majority step unit.
  always_comb begin
    maj = (lfsr_one_r[8] & lfsr_two_r[10]) | (lfsr_one_r[8] & lfsr_three_r[10]) |
          (lfsr_two_r[10] & lfsr_three_r[10]);
    step_one   = lfsr_one_r;
    step_two   = lfsr_two_r;
    step_three = lfsr_three_r;
    if (lfsr_one_r[8] == maj) begin
      step_one = {lfsr_one_r[13] ^ lfsr_one_r[16] ^ lfsr_one_r[17] ^ lfsr_one_r[18],
                  lfsr_one_r[18:1]};
    end
    if (lfsr_two_r[10] == maj) begin
      step_two = {lfsr_two_r[20] ^ lfsr_two_r[21], lfsr_two_r[21:1]};
    end
    if (lfsr_three_r[10] == maj) begin
      step_three = {lfsr_three_r[7] ^ lfsr_three_r[20] ^ lfsr_three_r[21] ^
                    lfsr_three_r[22], lfsr_three_r[22:1]};
    end
    step_bit = step_one[18] ^ step_two[21] ^ step_three[22];
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_fire         = in_ch.valid && (state_r == ST_IDLE);
  assign slot_free       = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign cfg_ch.ready    = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    warm_cnt_nxt   = warm_cnt_r;
    bit_cnt_nxt    = bit_cnt_r;
    lfsr_one_nxt   = lfsr_one_r;
    lfsr_two_nxt   = lfsr_two_r;
    lfsr_three_nxt = lfsr_three_r;
    data_nxt       = data_r;
    ks_nxt         = ks_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          data_nxt     = in_ch.data_in;
          bit_cnt_nxt  = '0;
          warm_cnt_nxt = '0;
          if (in_ch.start_of_message) begin
            lfsr_one_nxt   = load_one[18:0];
            lfsr_two_nxt   = load_two[21:0];
            lfsr_three_nxt = load_three;
            state_nxt      = (mcsc_pkg::WARMUP_STEPS != 0) ? ST_WARM : ST_RUN;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_WARM: begin
        lfsr_one_nxt   = step_one;
        lfsr_two_nxt   = step_two;
        lfsr_three_nxt = step_three;
        warm_cnt_nxt   = warm_cnt_r + 1'b1;
        if (warm_cnt_r == mcsc_pkg::WARM_CW'(mcsc_pkg::WARMUP_STEPS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        lfsr_one_nxt       = step_one;
        lfsr_two_nxt       = step_two;
        lfsr_three_nxt     = step_three;
        ks_nxt[bit_cnt_r]  = step_bit;
        bit_cnt_nxt        = bit_cnt_r + 1'b1;
        if (bit_cnt_r == 3'd7) begin
          if (slot_free) begin
            out_data_nxt  = data_r ^ {step_bit, ks_r[6:0]};
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        // keystream is complete; wait for the output register to drain
        if (slot_free) begin
          out_data_nxt  = data_r ^ ks_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      lfsr_one_r   <= '0;
      lfsr_two_r   <= '0;
      lfsr_three_r <= '0;
      key_r        <= mcsc_pkg::KEY_RESET;
      frame_r      <= mcsc_pkg::FRAME_RESET;
      warm_cnt_r   <= '0;
      bit_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      lfsr_one_r   <= lfsr_one_nxt;
      lfsr_two_r   <= lfsr_two_nxt;
      lfsr_three_r <= lfsr_three_nxt;
      warm_cnt_r   <= warm_cnt_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == mcsc_pkg::CFG_KEY) begin
          key_r <= cfg_ch.data;
        end else if (cfg_ch.index == mcsc_pkg::CFG_FRAME) begin
          frame_r <= cfg_ch.data[21:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    ks_r       <= ks_nxt;
    out_data_r <= out_data_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("sequencer idle right after accepting a beat");

  a_warm_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WARM |=> state_r == ST_WARM || state_r == ST_RUN)
    else $error("warm-up left to an unexpected state");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && bit_cnt_r != 3'd7 |=> state_r == ST_RUN)
    else $error("keystream run ended before eight steps");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RUN || $past(state_r) == ST_HOLD)
    else $error("result appeared without a finished keystream byte");

  a_hold_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && bit_cnt_r == 3'd7 && !out_valid_r |=> state_r == ST_IDLE)
    else $error("byte held although the output register was empty");

endmodule

FILE: sim/mcsc_checker.sv
`timescale 1ns / 1ps

module mcsc_checker (
  input  logic        clk,
  input  logic        rst_n,
  mcsc_in_if          in_mon,
  mcsc_out_if         out_mon,
  mcsc_cfg_if         cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending
);

  mcsc_pkg::key_t                   session_key;
  mcsc_pkg::frame_t                 frame_no;
  logic [mcsc_pkg::LEN_ONE-1:0]     sr_a;
  logic [mcsc_pkg::LEN_TWO-1:0]     sr_b;
  logic [mcsc_pkg::LEN_THREE-1:0]   sr_c;
  mcsc_pkg::byte_t                  expected_bytes[$];
  int unsigned                      mismatches;

  // Step each register whose clocking bit agrees with the majority.
  function automatic void majority_clock();
    logic ta, tb, tc, vote;
    ta = sr_a[8];
    tb = sr_b[10];
    tc = sr_c[10];
    vote = (ta & tb) | (ta & tc) | (tb & tc);
    if (ta == vote) sr_a = {sr_a[13] ^ sr_a[16] ^ sr_a[17] ^ sr_a[18], sr_a[18:1]};
    if (tb == vote) sr_b = {sr_b[20] ^ sr_b[21], sr_b[21:1]};
    if (tc == vote) sr_c = {sr_c[7] ^ sr_c[20] ^ sr_c[21] ^ sr_c[22], sr_c[22:1]};
  endfunction

  function automatic mcsc_pkg::byte_t cipher_byte(input mcsc_pkg::byte_t plain,
                                                  input logic restart);
    mcsc_pkg::byte_t ks;
    ks = '0;
    if (restart) begin
      // Key bits walk down from the top bit and wrap; later bits overwrite.
      for (int i = 0; i < 64; i++) begin
        sr_a[mcsc_pkg::LEN_ONE - 1 - (i % mcsc_pkg::LEN_ONE)]     = session_key[i];
        sr_b[mcsc_pkg::LEN_TWO - 1 - (i % mcsc_pkg::LEN_TWO)]     = session_key[i];
        sr_c[mcsc_pkg::LEN_THREE - 1 - (i % mcsc_pkg::LEN_THREE)] = session_key[i];
      end
      for (int i = 0; i < 22; i++) begin
        sr_a[mcsc_pkg::LEN_ONE - 1 - (i % mcsc_pkg::LEN_ONE)]     ^= frame_no[i];
        sr_b[mcsc_pkg::LEN_TWO - 1 - (i % mcsc_pkg::LEN_TWO)]     ^= frame_no[i];
        sr_c[mcsc_pkg::LEN_THREE - 1 - (i % mcsc_pkg::LEN_THREE)] ^= frame_no[i];
      end
      repeat (mcsc_pkg::WARMUP_STEPS) majority_clock();
    end
    for (int i = 0; i < 8; i++) begin
      majority_clock();
      ks[i] = sr_a[mcsc_pkg::LEN_ONE-1] ^ sr_b[mcsc_pkg::LEN_TWO-1] ^
              sr_c[mcsc_pkg::LEN_THREE-1];
    end
    return plain ^ ks;
  endfunction

  always @(posedge clk) begin
    mcsc_pkg::byte_t want;
    if (!rst_n) begin
      session_key = mcsc_pkg::KEY_RESET;
      frame_no    = mcsc_pkg::FRAME_RESET;
      sr_a        = '0;
      sr_b        = '0;
      sr_c        = '0;
      mismatches  = 0;
      expected_bytes.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("data_out: expected no beat, got %02h", out_mon.data_out);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_mon.data_out !== want) begin
            $error("data_out: expected %02h, got %02h", want, out_mon.data_out);
            mismatches++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == mcsc_pkg::CFG_KEY) session_key = cfg_mon.data;
        else if (cfg_mon.index == mcsc_pkg::CFG_FRAME) frame_no = cfg_mon.data[21:0];
      end
      if (in_mon.valid && in_mon.ready)
        expected_bytes.insert(expected_bytes.size(),
                              cipher_byte(in_mon.data_in, in_mon.start_of_message));
    end
    pending    <= expected_bytes.size();
    fail_count <= mismatches;
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 128;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 120;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  mcsc_in_if  in_ch ();
  mcsc_out_if out_ch ();
  mcsc_cfg_if cfg_ch ();

  majority_clocked_lfsr_stream_cipher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mcsc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: runs of ready, broken by stall bursts while stall_pct is nonzero.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Leave valid high after a beat; the next call either replaces the data or
  // opens a gap, so valid gets one assignment per edge.
  task automatic send_beat(input mcsc_pkg::byte_t value, input logic restart);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.data_in          <= value;
    in_ch.start_of_message <= restart;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Hold the sender until every outstanding byte has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input mcsc_pkg::cfg_idx_t idx, input mcsc_pkg::key_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int             msg_len;
    int             sent;
    mcsc_pkg::key_t word;

    quiet_cycles            = 0;
    gap_pct                 = 0;
    stall_pct               = 0;
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.data_in          <= '0;
    in_ch.start_of_message <= 1'b0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= mcsc_pkg::CFG_KEY;
    cfg_ch.data            <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No start seen yet: registers are zero, bytes pass through.
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hA5, 1'b0);
    // Default key and frame, then a restart right after another restart.
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h3C, 1'b0);
    send_beat(8'h81, 1'b1);
    send_beat(8'h81, 1'b1);
    drain();
    // All-zero key and frame give an all-zero keystream.
    write_reg(mcsc_pkg::CFG_KEY, '0);
    write_reg(mcsc_pkg::CFG_FRAME, '0);
    send_beat(8'h55, 1'b1);
    send_beat(8'hAA, 1'b0);
    drain();
    write_reg(mcsc_pkg::CFG_KEY, '1);
    write_reg(mcsc_pkg::CFG_FRAME, {42'h0, 22'h3FFFFF});
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h12, 1'b0);
    drain();
    // New key inside a message waits for the next restart.
    write_reg(mcsc_pkg::CFG_KEY, {$urandom, $urandom});
    send_beat(8'h34, 1'b0);
    send_beat(8'h56, 1'b0);
    send_beat(8'h78, 1'b1);
    drain();
    // Upper data bits of a frame write are dropped.
    write_reg(mcsc_pkg::CFG_FRAME, {$urandom, $urandom});
    send_beat(8'h9C, 1'b1);
    send_beat(8'h01, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph >= PHASES - 2) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      case ($urandom_range(0, 5))
        0: word = '0;
        1: word = '1;
        default: word = {$urandom, $urandom};
      endcase
      if (ph < 2 || $urandom_range(0, 3) != 0) write_reg(mcsc_pkg::CFG_KEY, word);
      word = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: word[21:0] = '0;
        1: word[21:0] = '1;
        default: ;
      endcase
      if (ph < 2 || $urandom_range(0, 3) != 0) write_reg(mcsc_pkg::CFG_FRAME, word);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 20);
        // Now and then run on without a restart.
        send_beat(mcsc_pkg::byte_t'($urandom_range(0, 255)), $urandom_range(0, 7) != 0);
        sent++;
        for (int k = 0; k < msg_len; k++) begin
          send_beat(mcsc_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
          sent++;
        end
        if ($urandom_range(0, 15) == 0) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
